// ----- rtl/core/tks_pkg.sv -----
// ----------------------------------------------------------------------------
// tks_pkg: shared types, codes and character helpers of the token scanner
// holds token kinds, keyword list, result record and position width
// ----------------------------------------------------------------------------
package tks_pkg;

    // sizing
    localparam int KEYWORD_MAX_LEN = 8;
    localparam int POSITION_BITS   = 32;
    localparam int POS_EXT_W       = (POSITION_BITS > 32) ? POSITION_BITS : 32;
    localparam int KW_TEXT_BYTES   = 8;
    localparam int KW_IDX_W        = $clog2(KW_TEXT_BYTES);
    localparam int KW_COUNT        = 15;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W      = FIFO_PTR_W + 1;

    // token kinds
    localparam logic [5:0] K_ID      = 6'd13;
    localparam logic [5:0] K_NUMBER  = 6'd14;
    localparam logic [5:0] K_STRING  = 6'd15;
    localparam logic [5:0] K_PLUS    = 6'd16;
    localparam logic [5:0] K_MINUS   = 6'd17;
    localparam logic [5:0] K_MULT    = 6'd18;
    localparam logic [5:0] K_DIV     = 6'd19;
    localparam logic [5:0] K_MOD     = 6'd20;
    localparam logic [5:0] K_ASSIGN  = 6'd21;
    localparam logic [5:0] K_NOT     = 6'd22;
    localparam logic [5:0] K_LT      = 6'd23;
    localparam logic [5:0] K_LE      = 6'd24;
    localparam logic [5:0] K_GT      = 6'd25;
    localparam logic [5:0] K_GE      = 6'd26;
    localparam logic [5:0] K_NE      = 6'd27;
    localparam logic [5:0] K_EQ      = 6'd28;
    localparam logic [5:0] K_INS     = 6'd29;
    localparam logic [5:0] K_EXT     = 6'd30;
    localparam logic [5:0] K_COMMA   = 6'd31;
    localparam logic [5:0] K_SEMI    = 6'd32;
    localparam logic [5:0] K_LPAREN  = 6'd33;
    localparam logic [5:0] K_RPAREN  = 6'd34;
    localparam logic [5:0] K_UNKNOWN = 6'd35;
    localparam logic [5:0] K_EOF     = 6'd36;

    // characters with a meaning of their own
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // keyword list, text left-aligned with first character in the top byte
    localparam logic [8*KW_TEXT_BYTES-1:0] KW_TEXT [KW_COUNT] = '{
        {"begin", 24'h0}, {"break", 24'h0}, {"cin", 40'h0}, "continue",
        {"cout", 32'h0}, {"do", 48'h0}, {"else", 32'h0}, {"end", 40'h0},
        {"if", 48'h0}, {"int", 40'h0}, {"loop", 32'h0}, {"then", 32'h0},
        {"while", 24'h0}, {"exit", 32'h0}, {"newline", 8'h0}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd5, 4'd3, 4'd8, 4'd4, 4'd2, 4'd4, 4'd3,
        4'd2, 4'd3, 4'd4, 4'd4, 4'd5, 4'd4, 4'd7
    };
    localparam logic [5:0] KW_KIND [KW_COUNT] = '{
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7,
        6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd37, 6'd38
    };

    // one result record
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [15:0] length;
        logic        err;
        logic        last;
    } tks_result_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c == CH_UNDER) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // keyword match over the zero-padded buffer
    function automatic logic [5:0] ident_kind(input logic [8*KW_TEXT_BYTES-1:0] word,
                                              input logic [15:0] count);
        logic [5:0] kind;
        kind = K_ID;
        if (count <= 16'(KEYWORD_MAX_LEN)) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                if (count == 16'(KW_LEN[i]) && word == KW_TEXT[i]) begin
                    kind = KW_KIND[i];
                end
            end
        end
        return kind;
    endfunction

    // low 32 bits of a position, zero-extended when positions are narrower
    function automatic logic [31:0] pos_to_start(input logic [POSITION_BITS-1:0] p);
        logic [POS_EXT_W-1:0] wide;
        wide = POS_EXT_W'(p);
        return wide[31:0];
    endfunction

endpackage

// ----- rtl/core/token_scanner.sv -----
// ----------------------------------------------------------------------------
// token_scanner: streaming lexical scanner, one source byte per transfer
// ----------------------------------------------------------------------------
// Input channel s_*: one character per transfer in s_tdata; s_tlast high marks
// the end of the source, and s_tdata of that transfer is ignored.
// Output channel m_*: one token per transfer. m_tdata carries start offset and
// length, m_tuser the kind and the scan error flag, m_tlast marks the last
// token caused by one input transfer.
// A character lands in an input register, is scanned from there once the queue
// has room for two results, and its tokens enter a four-entry result queue that
// feeds the output channel.
// One character per cycle is sustained as
// long as each character yields at most one token and the receiver keeps up;
// a character that closes a token and forms another yields two, and the queue
// absorbs the extra one while the output drains one token per cycle.
// When the receiver stalls, the queue fills and s_tready falls once fewer
// than two queue entries are free; nothing is dropped.
// Reset clears the scanner to idle between tokens at offset zero and empties
// the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module token_scanner
    import tks_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // token_start[31:0], token_length[47:32]
    output logic [6:0]  m_tuser,   // token_kind[5:0], scan_error[6]
    output logic        m_tlast    // last_result
);

    logic                  in_vld_reg;
    logic [7:0]            in_char_reg;
    logic                  in_eoi_reg;
    logic                  advance;
    logic [1:0]            push_n;
    tks_result_t           res0, res1, head;
    logic                  not_empty;
    logic [FIFO_CNT_W-1:0] fill;

    // scan the held character when the queue has room for two results
    assign advance  = in_vld_reg && (fill <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign s_tready = !in_vld_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
    end

    tks_scan_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .char_code    (in_char_reg),
        .end_of_input (in_eoi_reg),
        .push_n       (push_n),
        .res0         (res0),
        .res1         (res1)
    );

    tks_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push0     (res0),
        .push1     (res1),
        .pop       (m_tvalid && m_tready),
        .head      (head),
        .not_empty (not_empty),
        .count     (fill)
    );

    // output channel
    assign m_tvalid = not_empty;
    assign m_tdata  = {head.length, head.start};
    assign m_tuser  = {head.err, head.kind};
    assign m_tlast  = head.last;

endmodule

// ----- rtl/core/tks_scan_core.sv -----
// ----------------------------------------------------------------------------
// tks_scan_core: scanner state and per-character token logic
// updates the scan mode on each step and forms up to two result records
// ----------------------------------------------------------------------------
module tks_scan_core
    import tks_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  char_code,
    input  logic        end_of_input,
    output logic [1:0]  push_n,
    output tks_result_t res0,
    output tks_result_t res1
);

    // scan modes
    localparam logic [3:0] M_IDLE   = 4'd0;
    localparam logic [3:0] M_IDENT  = 4'd1;
    localparam logic [3:0] M_NUMBER = 4'd2;
    localparam logic [3:0] M_SLASH  = 4'd3;
    localparam logic [3:0] M_LINE   = 4'd4;
    localparam logic [3:0] M_BLOCK  = 4'd5;
    localparam logic [3:0] M_BSTAR  = 4'd6;
    localparam logic [3:0] M_STRING = 4'd7;
    localparam logic [3:0] M_LT     = 4'd8;
    localparam logic [3:0] M_GT     = 4'd9;
    localparam logic [3:0] M_BANG   = 4'd10;
    localparam logic [3:0] M_EQ     = 4'd11;

    logic [3:0]               mode_reg,   mode_next;
    logic [15:0]              count_reg,  count_next;
    logic [POSITION_BITS-1:0] origin_reg, origin_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;
    logic [7:0]               kbuf_reg [KW_TEXT_BYTES];
    logic [7:0]               kbuf_next [KW_TEXT_BYTES];

    logic [8*KW_TEXT_BYTES-1:0] kw_word;
    logic [15:0]              count_bump;
    logic                     pend_v;
    logic [5:0]               pend_kind;
    logic [15:0]              pend_len;
    logic                     a_v, b_v, run_idle;
    tks_result_t              a_res, b_res;
    logic [31:0]              pos_start, origin_start;

    // buffer as one word, first character in the top byte
    always_comb begin
        for (int i = 0; i < KW_TEXT_BYTES; i++) begin
            kw_word[8*(KW_TEXT_BYTES-1-i) +: 8] = kbuf_reg[i];
        end
    end

    assign count_bump   = (count_reg != 16'hFFFF) ? count_reg + 16'd1 : count_reg;
    assign pos_start    = pos_to_start(pos_reg);
    assign origin_start = pos_to_start(origin_reg);

    // token that a non-extending character closes
    always_comb begin
        pend_v    = 1'b1;
        pend_kind = K_ID;
        pend_len  = 16'd1;
        unique case (mode_reg)
            M_IDENT: begin
                pend_kind = ident_kind(kw_word, count_reg);
                pend_len  = count_reg;
            end
            M_NUMBER: begin
                pend_kind = K_NUMBER;
                pend_len  = count_reg;
            end
            M_SLASH: pend_kind = K_DIV;
            M_LT:    pend_kind = K_LT;
            M_GT:    pend_kind = K_GT;
            M_BANG:  pend_kind = K_NOT;
            M_EQ:    pend_kind = K_ASSIGN;
            default: pend_v = 1'b0;
        endcase
    end

    // mode update and result forming
    always_comb begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        origin_next = origin_reg;
        pos_next    = pos_reg;
        kbuf_next   = kbuf_reg;
        a_v         = 1'b0;
        b_v         = 1'b0;
        run_idle    = 1'b0;
        a_res       = '{kind: pend_kind, start: origin_start, length: pend_len,
                        err: 1'b0, last: 1'b0};
        b_res       = '{kind: K_EOF, start: pos_start, length: 16'd0,
                        err: 1'b0, last: 1'b1};

        if (end_of_input) begin
            // flush a pending token, then the eof token
            if (mode_reg == M_STRING || mode_reg == M_LINE ||
                mode_reg == M_BLOCK || mode_reg == M_BSTAR) begin
                b_res.err = 1'b1;
            end else begin
                a_v = pend_v;
            end
            b_v        = 1'b1;
            mode_next  = M_IDLE;
            count_next = 16'd0;
        end else begin
            unique case (mode_reg)
                M_IDENT: begin
                    if (is_letter(char_code)) begin
                        if (count_reg < 16'(KW_TEXT_BYTES)) begin
                            kbuf_next[count_reg[KW_IDX_W-1:0]] = char_code;
                        end
                        count_next = count_bump;
                    end else begin
                        a_v      = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(char_code)) begin
                        count_next = count_bump;
                    end else begin
                        a_v      = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (char_code == CH_SLASH) begin
                        mode_next = M_LINE;
                    end else if (char_code == CH_STAR) begin
                        mode_next = M_BLOCK;
                    end else begin
                        a_v      = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                M_LINE: begin
                    if (char_code == CH_NL) mode_next = M_IDLE;
                end
                M_BLOCK: begin
                    if (char_code == CH_STAR) mode_next = M_BSTAR;
                end
                M_BSTAR: begin
                    if (char_code == CH_SLASH) begin
                        mode_next = M_IDLE;
                    end else if (char_code != CH_STAR) begin
                        mode_next = M_BLOCK;
                    end
                end
                M_STRING: begin
                    if (char_code == CH_QUOTE) begin
                        a_v          = 1'b1;
                        a_res.kind   = K_STRING;
                        a_res.length = count_reg;
                        mode_next    = M_IDLE;
                    end else begin
                        count_next = count_bump;
                    end
                end
                M_LT, M_GT, M_BANG, M_EQ: begin
                    a_v = 1'b1;
                    if (char_code == CH_EQUAL) begin
                        a_res.length = 16'd2;
                        mode_next    = M_IDLE;
                        priority case (mode_reg)
                            M_LT:    a_res.kind = K_LE;
                            M_GT:    a_res.kind = K_GE;
                            M_BANG:  a_res.kind = K_NE;
                            default: a_res.kind = K_EQ;
                        endcase
                    end else if (mode_reg == M_LT && char_code == CH_LT) begin
                        a_res.kind   = K_INS;
                        a_res.length = 16'd2;
                        mode_next    = M_IDLE;
                    end else if (mode_reg == M_GT && char_code == CH_GT) begin
                        a_res.kind   = K_EXT;
                        a_res.length = 16'd2;
                        mode_next    = M_IDLE;
                    end else begin
                        run_idle = 1'b1;
                    end
                end
                default: run_idle = 1'b1;
            endcase

            // scan the character from idle
            if (run_idle) begin
                mode_next    = M_IDLE;
                b_res.start  = pos_start;
                b_res.length = 16'd1;
                b_res.kind   = K_UNKNOWN;
                if (is_space(char_code)) begin
                    b_v = 1'b0;
                end else if (is_letter(char_code)) begin
                    for (int i = 0; i < KW_TEXT_BYTES; i++) kbuf_next[i] = 8'h00;
                    kbuf_next[0] = char_code;
                    mode_next    = M_IDENT;
                    origin_next  = pos_reg;
                    count_next   = 16'd1;
                end else if (is_digit(char_code)) begin
                    mode_next   = M_NUMBER;
                    origin_next = pos_reg;
                    count_next  = 16'd1;
                end else begin
                    b_v = 1'b1;
                    priority case (char_code)
                        CH_PLUS:   b_res.kind = K_PLUS;
                        CH_MINUS:  b_res.kind = K_MINUS;
                        CH_STAR:   b_res.kind = K_MULT;
                        CH_PCT:    b_res.kind = K_MOD;
                        CH_COMMA:  b_res.kind = K_COMMA;
                        CH_SEMI:   b_res.kind = K_SEMI;
                        CH_LPAREN: b_res.kind = K_LPAREN;
                        CH_RPAREN: b_res.kind = K_RPAREN;
                        CH_SLASH, CH_LT, CH_GT, CH_BANG, CH_EQUAL: begin
                            b_v         = 1'b0;
                            origin_next = pos_reg;
                            count_next  = 16'd1;
                            priority case (char_code)
                                CH_SLASH: mode_next = M_SLASH;
                                CH_LT:    mode_next = M_LT;
                                CH_GT:    mode_next = M_GT;
                                CH_BANG:  mode_next = M_BANG;
                                default:  mode_next = M_EQ;
                            endcase
                        end
                        CH_QUOTE: begin
                            b_v         = 1'b0;
                            mode_next   = M_STRING;
                            origin_next = pos_reg + POSITION_BITS'(1);
                            count_next  = 16'd0;
                        end
                        default: b_res.kind = K_UNKNOWN;
                    endcase
                end
            end
            pos_next = pos_reg + POSITION_BITS'(1);
        end
    end

    // order results: closed token first, then the idle-scan or eof token
    always_comb begin
        res0      = a_v ? a_res : b_res;
        res0.last = !(a_v && b_v);
        res1      = b_res;
        res1.last = 1'b1;
        push_n    = step ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            count_reg  <= 16'd0;
            origin_reg <= '0;
            pos_reg    <= '0;
            for (int i = 0; i < KW_TEXT_BYTES; i++) kbuf_reg[i] <= 8'h00;
        end else if (step) begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            origin_reg <= origin_next;
            pos_reg    <= pos_next;
            kbuf_reg   <= kbuf_next;
        end
    end

    // end of input always leaves one eof result and an idle scanner
    a_eoi_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step && end_of_input |-> push_n != 2'd0)
        else $error("end of input gave no result");

    a_eoi_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && end_of_input |=> mode_reg == M_IDLE && count_reg == 16'd0)
        else $error("scanner not idle after end of input");

    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        step && end_of_input |=> $stable(pos_reg))
        else $error("end marker moved the position");

endmodule

// ----- rtl/core/tks_result_fifo.sv -----
// ----------------------------------------------------------------------------
// tks_result_fifo: result queue between scanner and output channel
// takes up to two records per cycle and hands out one per transfer
// ----------------------------------------------------------------------------
module tks_result_fifo
    import tks_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            push_n,
    input  tks_result_t           push0,
    input  tks_result_t           push1,
    input  logic                  pop,
    output tks_result_t           head,
    output logic                  not_empty,
    output logic [FIFO_CNT_W-1:0] count
);

    tks_result_t           mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg,  count_next;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, two write slots
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) mem[wr_ptr_reg] <= push0;
        if (push_n == 2'd2) mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push1;
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from empty result queue");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_n != 2'd0 |-> count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2))
        else $error("push into full result queue");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> count_reg == FIFO_CNT_W'(FIFO_PTR_W'(wr_ptr_reg - rd_ptr_reg)) ||
                 (count_reg == FIFO_CNT_W'(FIFO_DEPTH) && wr_ptr_reg == rd_ptr_reg))
        else $error("queue count disagrees with pointers");

endmodule

// ----- tb/sv/token_scanner_checker.sv -----
// ----------------------------------------------------------------------------
// token_scanner_checker: scoreboard for the token scanner
// follows every character transfer with its own scanner, queues the tokens it
// should cause and compares each token transfer against the oldest one
// ----------------------------------------------------------------------------
module token_scanner_checker
    import tks_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code
    input  logic        s_tlast,   // end_of_input
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // token_start[31:0], token_length[47:32]
    input  logic [6:0]  m_tuser,   // token_kind[5:0], scan_error[6]
    input  logic        m_tlast,   // last_result
    output int          fail_count,
    output int          tokens_owed
);

    // keyword kinds
    localparam logic [5:0] KW_BEGIN    = 6'd0;
    localparam logic [5:0] KW_BREAK    = 6'd1;
    localparam logic [5:0] KW_CIN      = 6'd2;
    localparam logic [5:0] KW_CONTINUE = 6'd3;
    localparam logic [5:0] KW_COUT     = 6'd4;
    localparam logic [5:0] KW_DO       = 6'd5;
    localparam logic [5:0] KW_ELSE     = 6'd6;
    localparam logic [5:0] KW_END      = 6'd7;
    localparam logic [5:0] KW_IF       = 6'd8;
    localparam logic [5:0] KW_INT      = 6'd9;
    localparam logic [5:0] KW_LOOP     = 6'd10;
    localparam logic [5:0] KW_THEN     = 6'd11;
    localparam logic [5:0] KW_WHILE    = 6'd12;
    localparam logic [5:0] KW_EXIT     = 6'd37;
    localparam logic [5:0] KW_NEWLINE  = 6'd38;

    localparam int KW_BUF_LEN = 8;
    localparam int MAX_SHOWN  = 10;

    typedef enum logic [3:0] {
        SM_IDLE, SM_IDENT, SM_NUMBER, SM_SLASH, SM_LINE, SM_BLOCK, SM_BSTAR,
        SM_STRING, SM_LT, SM_GT, SM_BANG, SM_EQ
    } scan_mode_t;

    scan_mode_t  lex_mode;
    logic [7:0]  kw_buf [KW_BUF_LEN];
    logic [15:0] lex_count;
    logic [31:0] lex_origin;
    logic [31:0] char_pos;
    int          step_tokens;
    int          shown;

    tks_result_t due_tokens [$];
    tks_result_t want;
    tks_result_t got;

    function automatic logic is_word_char(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER};
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function void add_token(input logic [5:0] kind, input logic [31:0] start,
                            input logic [15:0] len, input logic err);
        due_tokens.push_back('{kind, start, len, err, 1'b0});
        step_tokens++;
    endfunction

    // keyword lookup; the buffer is zero past the word, so equal words have equal length
    function automatic logic [5:0] word_kind();
        logic [63:0] word;
        logic [5:0]  kind;
        kind = K_ID;
        for (int i = 0; i < KW_BUF_LEN; i++) word[63-8*i -: 8] = kw_buf[i];
        if (lex_count <= 16'(KEYWORD_MAX_LEN)) begin
            case (word)
                {"begin", 24'h0}:   kind = KW_BEGIN;
                {"break", 24'h0}:   kind = KW_BREAK;
                {"cin", 40'h0}:     kind = KW_CIN;
                "continue":         kind = KW_CONTINUE;
                {"cout", 32'h0}:    kind = KW_COUT;
                {"do", 48'h0}:      kind = KW_DO;
                {"else", 32'h0}:    kind = KW_ELSE;
                {"end", 40'h0}:     kind = KW_END;
                {"if", 48'h0}:      kind = KW_IF;
                {"int", 40'h0}:     kind = KW_INT;
                {"loop", 32'h0}:    kind = KW_LOOP;
                {"then", 32'h0}:    kind = KW_THEN;
                {"while", 24'h0}:   kind = KW_WHILE;
                {"exit", 32'h0}:    kind = KW_EXIT;
                {"newline", 8'h0}:  kind = KW_NEWLINE;
                default: ;
            endcase
        end
        return kind;
    endfunction

    // close a token that the current character cannot extend
    function void flush_pending();
        case (lex_mode)
            SM_IDENT:  add_token(word_kind(), lex_origin, lex_count, 1'b0);
            SM_NUMBER: add_token(K_NUMBER, lex_origin, lex_count, 1'b0);
            SM_SLASH:  add_token(K_DIV, lex_origin, 16'd1, 1'b0);
            SM_LT:     add_token(K_LT, lex_origin, 16'd1, 1'b0);
            SM_GT:     add_token(K_GT, lex_origin, 16'd1, 1'b0);
            SM_BANG:   add_token(K_NOT, lex_origin, 16'd1, 1'b0);
            SM_EQ:     add_token(K_ASSIGN, lex_origin, 16'd1, 1'b0);
            default: ;
        endcase
        lex_mode = SM_IDLE;
    endfunction

    function void open_token(input scan_mode_t m, input logic [31:0] p);
        lex_mode   = m;
        lex_origin = p;
        lex_count  = 16'd1;
    endfunction

    function void grow_count();
        if (lex_count != 16'hFFFF) lex_count++;
    endfunction

    // character seen between tokens
    function void scan_from_idle(input logic [7:0] c, input logic [31:0] p);
        if (is_blank(c)) return;
        if (is_word_char(c)) begin
            foreach (kw_buf[i]) kw_buf[i] = 8'h00;
            kw_buf[0] = c;
            open_token(SM_IDENT, p);
            return;
        end
        if (is_decimal(c)) begin
            open_token(SM_NUMBER, p);
            return;
        end
        case (c)
            CH_PLUS:   add_token(K_PLUS, p, 16'd1, 1'b0);
            CH_MINUS:  add_token(K_MINUS, p, 16'd1, 1'b0);
            CH_STAR:   add_token(K_MULT, p, 16'd1, 1'b0);
            CH_PCT:    add_token(K_MOD, p, 16'd1, 1'b0);
            CH_COMMA:  add_token(K_COMMA, p, 16'd1, 1'b0);
            CH_SEMI:   add_token(K_SEMI, p, 16'd1, 1'b0);
            CH_LPAREN: add_token(K_LPAREN, p, 16'd1, 1'b0);
            CH_RPAREN: add_token(K_RPAREN, p, 16'd1, 1'b0);
            CH_SLASH:  open_token(SM_SLASH, p);
            CH_LT:     open_token(SM_LT, p);
            CH_GT:     open_token(SM_GT, p);
            CH_BANG:   open_token(SM_BANG, p);
            CH_EQUAL:  open_token(SM_EQ, p);
            CH_QUOTE: begin
                // string lexeme starts after the quote
                lex_mode   = SM_STRING;
                lex_origin = p + 32'd1;
                lex_count  = 16'd0;
            end
            default:   add_token(K_UNKNOWN, p, 16'd1, 1'b0);
        endcase
    endfunction

    // second character of a two-character operator; 0 means rescan from idle
    function automatic logic pair_second(input logic [7:0] c,
                                         input logic [7:0] a, input logic [5:0] ka,
                                         input logic has_b,
                                         input logic [7:0] b, input logic [5:0] kb);
        if (c == a) begin
            add_token(ka, lex_origin, 16'd2, 1'b0);
            lex_mode = SM_IDLE;
            return 1'b1;
        end
        if (has_b && c == b) begin
            add_token(kb, lex_origin, 16'd2, 1'b0);
            lex_mode = SM_IDLE;
            return 1'b1;
        end
        flush_pending();
        return 1'b0;
    endfunction

    // one accepted input transfer
    function void scan_byte(input logic [7:0] c, input logic eoi);
        logic taken;
        taken       = 1'b0;
        step_tokens = 0;
        if (eoi) begin
            // end of source: pending token, then eof; inside string or comment only eof
            if (lex_mode inside {SM_STRING, SM_LINE, SM_BLOCK, SM_BSTAR}) begin
                lex_mode = SM_IDLE;
                add_token(K_EOF, char_pos, 16'd0, 1'b1);
            end else begin
                flush_pending();
                add_token(K_EOF, char_pos, 16'd0, 1'b0);
            end
            lex_count = 16'd0;
            due_tokens[$].last = 1'b1;
            return;
        end
        case (lex_mode)
            SM_IDENT: begin
                if (is_word_char(c)) begin
                    if (lex_count < 16'(KW_BUF_LEN)) kw_buf[lex_count[2:0]] = c;
                    grow_count();
                    taken = 1'b1;
                end else begin
                    flush_pending();
                end
            end
            SM_NUMBER: begin
                if (is_decimal(c)) begin
                    grow_count();
                    taken = 1'b1;
                end else begin
                    flush_pending();
                end
            end
            SM_SLASH: begin
                if (c == CH_SLASH) begin
                    lex_mode = SM_LINE;
                    taken    = 1'b1;
                end else if (c == CH_STAR) begin
                    lex_mode = SM_BLOCK;
                    taken    = 1'b1;
                end else begin
                    flush_pending();
                end
            end
            SM_LINE: begin
                if (c == CH_NL) lex_mode = SM_IDLE;
                taken = 1'b1;
            end
            SM_BLOCK: begin
                if (c == CH_STAR) lex_mode = SM_BSTAR;
                taken = 1'b1;
            end
            SM_BSTAR: begin
                if (c == CH_SLASH) lex_mode = SM_IDLE;
                else if (c != CH_STAR) lex_mode = SM_BLOCK;
                taken = 1'b1;
            end
            SM_STRING: begin
                if (c == CH_QUOTE) begin
                    add_token(K_STRING, lex_origin, lex_count, 1'b0);
                    lex_mode = SM_IDLE;
                end else begin
                    grow_count();
                end
                taken = 1'b1;
            end
            SM_LT:   taken = pair_second(c, CH_EQUAL, K_LE, 1'b1, CH_LT, K_INS);
            SM_GT:   taken = pair_second(c, CH_EQUAL, K_GE, 1'b1, CH_GT, K_EXT);
            SM_BANG: taken = pair_second(c, CH_EQUAL, K_NE, 1'b0, 8'h00, K_NE);
            SM_EQ:   taken = pair_second(c, CH_EQUAL, K_EQ, 1'b0, 8'h00, K_EQ);
            default: lex_mode = SM_IDLE;
        endcase
        if (!taken) scan_from_idle(c, char_pos);
        char_pos = char_pos + 32'd1;
        if (step_tokens > 0) due_tokens[$].last = 1'b1;
    endfunction

    function void note_failure(input string what);
        fail_count++;
        if (shown < MAX_SHOWN) begin
            shown++;
            $display("%0t: %s: expected kind=%0d start=%0d len=%0d err=%0b last=%0b",
                     $time, what, want.kind, want.start, want.length, want.err, want.last);
            $display("%0t: %s: actual   kind=%0d start=%0d len=%0d err=%0b last=%0b",
                     $time, what, got.kind, got.start, got.length, got.err, got.last);
        end
    endfunction

    // follow input transfers, then check output transfers
    always @(posedge aclk) begin
        if (!aresetn) begin
            lex_mode   = SM_IDLE;
            foreach (kw_buf[i]) kw_buf[i] = 8'h00;
            lex_count  = 16'd0;
            lex_origin = 32'd0;
            char_pos   = 32'd0;
            fail_count = 0;
            shown      = 0;
            due_tokens.delete();
        end else begin
            if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got = '{m_tuser[5:0], m_tdata[31:0], m_tdata[47:32], m_tuser[6], m_tlast};
                if (due_tokens.size() == 0) begin
                    want = '0;
                    note_failure("unexpected token");
                end else begin
                    want = due_tokens.pop_front();
                    if (got.kind !== want.kind || got.start !== want.start ||
                        got.length !== want.length || got.err !== want.err ||
                        got.last !== want.last) begin
                        note_failure("token mismatch");
                    end
                end
            end
        end
        tokens_owed <= due_tokens.size();
    end

endmodule

// ----- tb/sv/token_scanner_tb.sv -----
// ----------------------------------------------------------------------------
// token_scanner_tb: stimulus and verdict for the token scanner
// feeds directed text, then random token sequences under three idling
// settings; the checker scores every token
// ----------------------------------------------------------------------------
module token_scanner_tb;
    import tks_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 667;

    typedef struct packed {
        logic [7:0] code;
        logic       eoi;
    } src_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // char_code
    logic        s_tlast  = 1'b0;    // end_of_input
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;            // token_start[31:0], token_length[47:32]
    logic [6:0]  m_tuser;            // token_kind[5:0], scan_error[6]
    logic        m_tlast;            // last_result

    int fail_count;
    int tokens_owed;
    int cycle_count = 0;
    int tx_idle_pct = 34;
    int rx_idle_pct = 57;
    int counted;

    src_item_t src_q [$];

    string kw_words [15] = '{"begin", "break", "cin", "continue", "cout", "do", "else",
                             "end", "if", "int", "loop", "then", "while", "exit",
                             "newline"};
    string op_words [19] = '{"+", "-", "*", "/", "%", "=", "==", "!", "!=", "<", "<=",
                             "<<", ">", ">=", ">>", ",", ";", "(", ")"};
    string odd_chars = "#$@.{}[]?~`^&|:'\\";

    token_scanner u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    token_scanner_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .tokens_owed (tokens_owed)
    );

    // clock
    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("token_scanner_tb NOT OK");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function void put(input logic [7:0] c);
        src_q.push_back('{c, 1'b0});
    endfunction

    function void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endfunction

    // end marker with a random, ignored character
    function void put_end();
        src_q.push_back('{8'($urandom_range(0, 255)), 1'b1});
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26) return 8'(8'h61 + r);
        if (r < 52) return 8'(8'h41 + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_byte_but(input logic [7:0] banned);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == banned);
        return b;
    endfunction

    // one random token, a separator, noise or a broken sequence
    function void gen_token();
        int sel;
        int len;
        int base;
        logic [7:0] b;
        sel  = $urandom_range(0, 99);
        base = src_q.size();
        if (sel < 15) begin
            put_text(kw_words[$urandom_range(0, 14)]);
            if ($urandom_range(0, 3) == 0) put(rand_letter());
        end else if (sel < 25) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            repeat (len) put(rand_letter());
        end else if (sel < 35) begin
            len = $urandom_range(1, 6);
            repeat (len) put(8'(8'h30 + $urandom_range(0, 9)));
        end else if (sel < 42) begin
            put(CH_QUOTE);
            len = $urandom_range(0, 6);
            repeat (len) put(rand_byte_but(CH_QUOTE));
            put(CH_QUOTE);
        end else if (sel < 62) begin
            put_text(op_words[$urandom_range(0, 18)]);
        end else if (sel < 67) begin
            put_text("//");
            len = $urandom_range(0, 6);
            repeat (len) put(rand_byte_but(CH_NL));
            put(CH_NL);
        end else if (sel < 72) begin
            put_text("/*");
            len = $urandom_range(0, 8);
            repeat (len) begin
                case ($urandom_range(0, 3))
                    0: put(CH_STAR);
                    1: put(CH_SLASH);
                    2: put(rand_letter());
                    default: put(8'($urandom_range(0, 255)));
                endcase
            end
            put_text("*/");
        end else if (sel < 85) begin
            // whitespace is skipped and does not count toward the item total
            len = $urandom_range(1, 3);
            repeat (len) begin
                b = 8'($urandom_range(8, 13));
                put((b == 8'd8) ? 8'h20 : b);
            end
            base = src_q.size();
        end else if (sel < 90) begin
            case ($urandom_range(0, 2))
                0: put(odd_chars[$urandom_range(0, odd_chars.len() - 1)]);
                1: put(8'($urandom_range(128, 255)));
                default: put(8'($urandom_range(0, 8)));
            endcase
        end else if (sel < 94) begin
            put(8'($urandom_range(0, 255)));
        end else if (sel < 97) begin
            // source ends inside a string or a comment
            case ($urandom_range(0, 2))
                0: put(CH_QUOTE);
                1: put_text("//");
                default: put_text("/*");
            endcase
            len = $urandom_range(0, 3);
            repeat (len) put(rand_letter());
            put_end();
        end else begin
            put_end();
        end
        counted += src_q.size() - base;
    endfunction

    // drive all queued characters, one transfer each
    task automatic send_all();
        src_item_t it;
        while (src_q.size() > 0) begin
            it = src_q.pop_front();
            while ($urandom_range(0, 99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= it.code;
            s_tlast  <= it.eoi;
            do @(posedge aclk); while (!s_tready);
        end
        s_tvalid <= 1'b0;
    endtask

    // sender holds off until every expected token has come out
    task automatic wait_drained();
        @(posedge aclk);
        while (tokens_owed != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: keyword, id/number split, two-char ops, token closed by a
        // token, extreme bytes, lone assign, "/*/" not closing, eof in a string
        put_text("if(x1>=9)<<!");
        put(8'hFF);
        put(8'h00);
        put_text("=/*/*/\"a");
        put_end();
        send_all();
        wait_drained();

        // random phases with different idling
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 57 : 0;
            rx_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 34 : 0;
            counted = 0;
            while (counted < PHASE_ITEMS) gen_token();
            put_end();
            send_all();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && tokens_owed == 0) begin
            $display("token_scanner_tb OK");
        end else begin
            $display("token_scanner_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/tks_pkg.sv
rtl/core/tks_scan_core.sv
rtl/core/tks_result_fifo.sv
rtl/core/token_scanner.sv
tb/sv/token_scanner_checker.sv
tb/sv/token_scanner_tb.sv
